// ===== design/septet_to_octet_packer_core_macros.svh =====
// Assertion macros used by the packer top-level design file.
`ifndef SEPTET_TO_OCTET_PACKER_CORE_MACROS_SVH
`define SEPTET_TO_OCTET_PACKER_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define S2O_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define S2O_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/s2o_pkg.sv =====
`timescale 1ns / 1ps

package s2o_pkg;

    // Field widths and constants of the packing scheme.
    localparam int SEPTET_BITS = 7;
    localparam int OCTET_BITS  = 8;
    localparam int COUNT_BITS  = 8;
    localparam int CARRY_LEN_W = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam logic [SEPTET_BITS-1:0] SEPTET_MASK = 7'h7F;
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX   = 8'hFF;

    // One queue entry: one or two octets produced by a single character.
    typedef struct packed {
        logic [OCTET_BITS-1:0] octet_a;
        logic [COUNT_BITS-1:0] count_a;
        logic                  last_a;
        logic                  has_b;
        logic [OCTET_BITS-1:0] octet_b;
        logic [COUNT_BITS-1:0] count_b;
    } s2o_entry_t;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } s2o_qstat_t;

    // Front state made visible for checking.
    typedef struct packed {
        logic [CARRY_LEN_W-1:0] carry_len;
        logic [COUNT_BITS-1:0]  emitted;
    } s2o_fstat_t;

endpackage

// ===== design/s2o_front.sv =====
`timescale 1ns / 1ps

module s2o_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [s2o_pkg::SEPTET_BITS-1:0]   char_code,
    input  logic                              last_char,
    input  s2o_pkg::s2o_qstat_t               q_stat,
    output logic                              push,
    output s2o_pkg::s2o_entry_t               push_entry,
    output s2o_pkg::s2o_fstat_t               f_stat
);
    import s2o_pkg::*;

    logic [SEPTET_BITS-1:0] carry_bits_reg, carry_bits_next;
    logic [CARRY_LEN_W-1:0] carry_len_reg, carry_len_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;

    logic [2*SEPTET_BITS-1:0] acc;
    logic [CARRY_LEN_W:0]     sum_len;
    logic [CARRY_LEN_W:0]     rem_len;
    logic [SEPTET_BITS-1:0]   rem_bits;
    logic                     emit_full;
    logic                     emit_flush;
    logic [COUNT_BITS-1:0]    cnt_a;
    logic [COUNT_BITS-1:0]    cnt_b;
    logic                     accept;

    assign s_axis_tready = !q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Place the new character above the carried bits.
    always_comb
    begin
        acc = {{SEPTET_BITS{1'b0}}, carry_bits_reg}
            | ({{SEPTET_BITS{1'b0}}, char_code & SEPTET_MASK} << carry_len_reg);
        sum_len   = {1'b0, carry_len_reg} + (CARRY_LEN_W+1)'(SEPTET_BITS);
        emit_full = sum_len >= (CARRY_LEN_W+1)'(OCTET_BITS);
        if (emit_full)
        begin
            rem_bits = SEPTET_BITS'(acc >> OCTET_BITS);
            rem_len  = sum_len - (CARRY_LEN_W+1)'(OCTET_BITS);
        end
        else
        begin
            rem_bits = acc[SEPTET_BITS-1:0];
            rem_len  = sum_len;
        end
        emit_flush = last_char && (rem_len != '0);
    end

    // Running counts for the octets of this character, saturating.
    always_comb
    begin
        cnt_a = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;
        cnt_b = (cnt_a == COUNT_MAX) ? COUNT_MAX : cnt_a + 1'b1;
    end

    // Build the queue entry; a lone flush octet goes into the first slot.
    always_comb
    begin
        push_entry.count_a = cnt_a;
        push_entry.count_b = cnt_b;
        push_entry.octet_b = {1'b0, rem_bits};
        if (emit_full)
        begin
            push_entry.octet_a = acc[OCTET_BITS-1:0];
            push_entry.last_a  = last_char && !emit_flush;
            push_entry.has_b   = emit_flush;
        end
        else
        begin
            push_entry.octet_a = {1'b0, rem_bits};
            push_entry.last_a  = 1'b1;
            push_entry.has_b   = 1'b0;
        end
        push = accept && (emit_full || last_char);
    end

    // Next carry state; the last character starts a new message.
    always_comb
    begin
        carry_bits_next = carry_bits_reg;
        carry_len_next  = carry_len_reg;
        count_next      = count_reg;
        if (accept)
        begin
            if (last_char)
            begin
                carry_bits_next = '0;
                carry_len_next  = '0;
                count_next      = '0;
            end
            else
            begin
                carry_bits_next = rem_bits;
                carry_len_next  = rem_len[CARRY_LEN_W-1:0];
                count_next      = emit_full ? cnt_a : count_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_bits_reg <= '0;
            carry_len_reg  <= '0;
            count_reg      <= '0;
        end
        else
        begin
            carry_bits_reg <= carry_bits_next;
            carry_len_reg  <= carry_len_next;
            count_reg      <= count_next;
        end
    end

    assign f_stat.carry_len = carry_len_reg;
    assign f_stat.emitted   = count_reg;

endmodule

// ===== design/s2o_queue.sv =====
`timescale 1ns / 1ps

module s2o_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  s2o_pkg::s2o_entry_t push_entry,
    input  logic                pop,
    output s2o_pkg::s2o_entry_t head_entry,
    output s2o_pkg::s2o_qstat_t q_stat
);
    import s2o_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    s2o_entry_t         slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic               do_push;
    logic               do_pop;

    assign q_stat.full  = (level_reg == LVL_W'(DEPTH));
    assign q_stat.empty = (level_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_entry   = slots_reg[rd_ptr_reg];

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== design/s2o_back.sv =====
`timescale 1ns / 1ps

module s2o_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  s2o_pkg::s2o_entry_t               head_entry,
    input  s2o_pkg::s2o_qstat_t               q_stat,
    output logic                              pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [s2o_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast
);
    import s2o_pkg::*;

    logic phase_reg, phase_next;
    logic out_accept;

    assign m_axis_tvalid = !q_stat.empty;
    assign out_accept    = m_axis_tvalid && m_axis_tready;

    // Select the first or second octet of the head entry.
    always_comb
    begin
        if (phase_reg)
        begin
            m_axis_tdata = {head_entry.count_b, head_entry.octet_b};
            m_axis_tlast = 1'b1;
        end
        else
        begin
            m_axis_tdata = {head_entry.count_a, head_entry.octet_a};
            m_axis_tlast = head_entry.last_a;
        end
    end

    // Release the entry after its final octet has gone out.
    always_comb
    begin
        phase_next = phase_reg;
        pop        = 1'b0;
        if (out_accept)
        begin
            if (head_entry.has_b && !phase_reg)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== design/septet_to_octet_packer_core.sv =====
`timescale 1ns / 1ps

// Packs 7-bit characters into octets, least significant bit first, as in SMS
// default-alphabet packing. One character is accepted every cycle while the
// internal queue has room; the output side delivers one octet per cycle
// while the queue holds entries and m_axis_tready is high. A character gives
// zero or one octet, except a final character that both completes an octet
// and leaves bits over for a flush octet, which gives two, both sent from one
// queue entry. The entry queue between the character front end and the octet
// back end (FIFO_DEPTH entries) absorbs output stalls, so input is only held
// off once that queue is full. A message of n characters gives ceil(7n/8)
// octets; each octet carries a running count that saturates at 255.
module septet_to_octet_packer_core #(
    parameter int FIFO_DEPTH = 4  // queue entries, 2 or more
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [6:0] char_code, [7] zero
    input  logic [s2o_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] packed_octet, [15:8] octet_count
    output logic [s2o_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast
);
    import s2o_pkg::*;

    `include "septet_to_octet_packer_core_macros.svh"

    logic       push;
    logic       pop;
    s2o_entry_t push_entry;
    s2o_entry_t head_entry;
    s2o_qstat_t q_stat;
    s2o_fstat_t f_stat;

    // Character front end: packing and classification.
    s2o_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .char_code     (s_axis_tdata[SEPTET_BITS-1:0]),
        .last_char     (s_axis_tlast),
        .q_stat        (q_stat),
        .push          (push),
        .push_entry    (push_entry),
        .f_stat        (f_stat)
    );

    // Entry queue between the two sides.
    s2o_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_stat     (q_stat)
    );

    // Octet back end.
    s2o_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_entry    (head_entry),
        .q_stat        (q_stat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A final character always leaves the front end with an empty carry.
    `S2O_ASSERT_NEXT(a_last_clears, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, (f_stat.carry_len == '0) && (f_stat.emitted == '0), "carry not cleared after last item")
    // Every delivered octet carries a count of at least one.
    `S2O_ASSERT_NOW(a_count_nonzero, clk, rst_n, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:OCTET_BITS] != '0, "octet count is zero")
    // A push is never issued into a full queue.
    `S2O_ASSERT_NOW(a_no_overflow, clk, rst_n, q_stat.full, !push, "push into full queue")

endmodule
